### rtl/i2c_master_transaction_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master transaction sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2cm_seq_pkg.sv
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Buffer sizing, command and bus codes, the phase type and shared structs.
// ----------------------------------------------------------------------------
package i2cm_seq_pkg;

  // Write buffer depth and the address width that follows from it.
  localparam int WRITE_DEPTH = 16;
  localparam int WBUF_AW     = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  // Incoming bus event codes.
  localparam logic [2:0] CMD_LOAD      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_ACK       = 3'd2;
  localparam logic [2:0] CMD_NACK      = 3'd3;
  localparam logic [2:0] CMD_RX        = 3'd4;
  localparam logic [2:0] CMD_STOP_DONE = 3'd5;
  // Codes with no meaning; they are always refused.
  localparam logic [2:0] CMD_RSVD_A    = 3'd6;
  localparam logic [2:0] CMD_RSVD_B    = 3'd7;

  // Bus operation codes issued with a result.
  localparam logic [2:0] BUS_NONE      = 3'd0;
  localparam logic [2:0] BUS_START     = 3'd1;
  localparam logic [2:0] BUS_STOP      = 3'd2;
  localparam logic [2:0] BUS_ACK       = 3'd3;
  localparam logic [2:0] BUS_NACK_STOP = 3'd4;

  // Transaction phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_REQ_DEV,
    PH_WRITE,
    PH_REQ_READ,
    PH_READ,
    PH_CLOSE
  } phase_t;

  // One bus event as held in the input register.
  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  index;
    logic [7:0]  data_byte;
    logic [6:0]  dev_addr;
    logic        read_request;
    logic [4:0]  write_count;
    logic [7:0]  read_count;
    logic [31:0] event_tag;
  } evt_t;

  // One result as held in the result register.
  typedef struct packed {
    logic [2:0]  bus_command;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        read_valid;
    logic [7:0]  read_index;
    logic [7:0]  read_byte;
    logic        done_res;
    logic [31:0] done_tag;
    logic        fault;
    logic        idle;
  } res_t;

  // Write port of the buffer.
  typedef struct packed {
    logic               en;
    logic [WBUF_AW-1:0] addr;
    logic [7:0]         data;
  } wbuf_wr_t;

  // Address byte with the direction bit in the least significant place.
  function automatic logic [7:0] addr_byte(input logic [6:0] addr, input logic rd);
    addr_byte = {addr, rd};
  endfunction

endpackage

### rtl/i2cm_seq_if.sv
// ----------------------------------------------------------------------------
// I2C master sequencer channel interfaces
// Valid/ready channels for bus events in and results out.
// ----------------------------------------------------------------------------

// Bus event channel.
interface i2cm_seq_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  index;
  logic [7:0]  data_byte;
  logic [6:0]  dev_addr;
  logic        read_request;
  logic [4:0]  write_count;
  logic [7:0]  read_count;
  logic [31:0] event_tag;

  modport source (
    output valid, command, index, data_byte, dev_addr, read_request,
           write_count, read_count, event_tag,
    input  ready
  );
  modport sink (
    input  valid, command, index, data_byte, dev_addr, read_request,
           write_count, read_count, event_tag,
    output ready
  );
endinterface

// Result channel.
interface i2cm_seq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  bus_command;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        read_valid;
  logic [7:0]  read_index;
  logic [7:0]  read_byte;
  logic        done_res;
  logic [31:0] done_tag;
  logic        fault;
  logic        idle;

  modport source (
    output valid, bus_command, tx_valid, tx_byte, read_valid, read_index,
           read_byte, done_res, done_tag, fault, idle,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_valid, tx_byte, read_valid, read_index,
           read_byte, done_res, done_tag, fault, idle,
    output ready
  );
endinterface

### rtl/i2cm_seq_wbuf.sv
// ----------------------------------------------------------------------------
// I2C master sequencer write buffer
// Store of outgoing data bytes, one write port and one registered read port.
// ----------------------------------------------------------------------------
module i2cm_seq_wbuf (
  input  logic                   clk,
  input  i2cm_seq_pkg::wbuf_wr_t wr,
  input  logic [4:0]             rd_pos,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [i2cm_seq_pkg::WRITE_DEPTH];

  // Entries hold whatever was last loaded; there is no reset.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // The read data is registered. A position past the end of the buffer reads
  // as zero.
  always_ff @(posedge clk) begin
    if (32'(rd_pos) < i2cm_seq_pkg::WRITE_DEPTH) begin
      rd_data <= mem[rd_pos[i2cm_seq_pkg::WBUF_AW-1:0]];
    end else begin
      rd_data <= 8'd0;
    end
  end

endmodule

### rtl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Turns bus events into START, data, repeated START, read and STOP steps.
// ----------------------------------------------------------------------------
// The sequencer takes one bus event per clock cycle unless a waiting result
// holds it up, and returns exactly one result for each: the event is first
// captured in an input register, then decoded against the current phase in a
// single pass of logic and written to the result register, at which point the
// phase and counters advance. The next event is therefore always decoded
// against the state left by the one before it. A result waiting on the output
// stalls the pipeline only once both registers are full. Load write bytes
// while idle, then send a start event; illegal events return a fault result
// and leave the state untouched.
module i2c_master_transaction_sequencer (
  input logic            clk,
  input logic            rst,
  i2cm_seq_evt_if.sink   bus_evt,
  i2cm_seq_res_if.source result
);

  // Input register
  logic                 s1_valid;
  i2cm_seq_pkg::evt_t   s1;
  logic                 out_free;
  logic                 advance;

  // Transaction state
  i2cm_seq_pkg::phase_t phase, phase_next;
  logic [6:0]           target_address, target_address_next;
  logic                 read_wanted, read_wanted_next;
  logic [4:0]           write_total, write_total_next;
  logic [7:0]           read_total, read_total_next;
  logic [4:0]           bytes_written, bytes_written_next;
  logic [7:0]           bytes_read, bytes_read_next;
  logic [31:0]          saved_tag, saved_tag_next;

  // Decode
  logic                 legal;
  logic                 load_in_range;
  logic [4:0]           wr_count_inc;
  logic [7:0]           rd_count_inc;
  logic                 wr_last;
  logic                 rd_last;
  i2cm_seq_pkg::phase_t pf_phase;
  logic [4:0]           pf_written;
  logic [4:0]           buf_pos;
  logic [7:0]           buf_data;
  i2cm_seq_pkg::wbuf_wr_t wbuf_wr;

  // Result register
  logic                 res_valid;
  i2cm_seq_pkg::res_t   res, res_next;

  // Handshake: an event moves on when the result register can take it.
  assign out_free      = !res_valid || result.ready;
  assign advance       = s1_valid && out_free;
  assign bus_evt.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bus_evt.ready) begin
      s1_valid <= bus_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bus_evt.ready && bus_evt.valid) begin
      s1.command      <= bus_evt.command;
      s1.index        <= bus_evt.index;
      s1.data_byte    <= bus_evt.data_byte;
      s1.dev_addr     <= bus_evt.dev_addr;
      s1.read_request <= bus_evt.read_request;
      s1.write_count  <= bus_evt.write_count;
      s1.read_count   <= bus_evt.read_count;
      s1.event_tag    <= bus_evt.event_tag;
    end
  end

  // Counter steps and end-of-phase tests.
  assign wr_count_inc  = bytes_written + 5'd1;
  assign rd_count_inc  = bytes_read + 8'd1;
  assign wr_last       = wr_count_inc >= write_total;
  assign rd_last       = rd_count_inc >= read_total;
  assign load_in_range = 32'(s1.index) < i2cm_seq_pkg::WRITE_DEPTH;

  // The buffer read is registered, so its position is set from the state that
  // the next event will see. The first data byte comes from position zero,
  // later ones follow the count. Loads happen only while idle, so the fetched
  // byte is always current by the time it is sent.
  assign pf_phase   = advance ? phase_next : phase;
  assign pf_written = advance ? bytes_written_next : bytes_written;
  assign buf_pos    = (pf_phase == i2cm_seq_pkg::PH_REQ_DEV) ? 5'd0 : pf_written + 5'd1;

  assign wbuf_wr.en   = advance && legal && (s1.command == i2cm_seq_pkg::CMD_LOAD);
  assign wbuf_wr.addr = s1.index[i2cm_seq_pkg::WBUF_AW-1:0];
  assign wbuf_wr.data = s1.data_byte;

  i2cm_seq_wbuf u_wbuf (
    .clk     (clk),
    .wr      (wbuf_wr),
    .rd_pos  (buf_pos),
    .rd_data (buf_data)
  );

  // Which events the current phase accepts.
  always_comb begin
    case (s1.command)
      i2cm_seq_pkg::CMD_LOAD:      legal = (phase == i2cm_seq_pkg::PH_IDLE) && load_in_range;
      i2cm_seq_pkg::CMD_START:     legal = (phase == i2cm_seq_pkg::PH_IDLE);
      i2cm_seq_pkg::CMD_ACK:       legal = phase inside {i2cm_seq_pkg::PH_REQ_DEV,
                                                         i2cm_seq_pkg::PH_WRITE,
                                                         i2cm_seq_pkg::PH_REQ_READ};
      i2cm_seq_pkg::CMD_NACK:      legal = (phase == i2cm_seq_pkg::PH_REQ_READ) && read_wanted;
      i2cm_seq_pkg::CMD_RX:        legal = (phase == i2cm_seq_pkg::PH_READ);
      i2cm_seq_pkg::CMD_STOP_DONE: legal = (phase == i2cm_seq_pkg::PH_CLOSE);
      default:                     legal = 1'b0;
    endcase
  end

  // Next phase and counters.
  always_comb begin
    phase_next          = phase;
    target_address_next = target_address;
    read_wanted_next    = read_wanted;
    write_total_next    = write_total;
    read_total_next     = read_total;
    bytes_written_next  = bytes_written;
    bytes_read_next     = bytes_read;
    saved_tag_next      = saved_tag;
    if (legal) begin
      case (s1.command)
        i2cm_seq_pkg::CMD_START: begin
          target_address_next = s1.dev_addr;
          read_wanted_next    = s1.read_request;
          write_total_next    = (32'(s1.write_count) > i2cm_seq_pkg::WRITE_DEPTH) ?
                                5'(i2cm_seq_pkg::WRITE_DEPTH) : s1.write_count;
          read_total_next     = s1.read_count;
          bytes_written_next  = 5'd0;
          bytes_read_next     = 8'd0;
          saved_tag_next      = s1.event_tag;
          phase_next          = i2cm_seq_pkg::PH_REQ_DEV;
        end
        i2cm_seq_pkg::CMD_ACK: begin
          case (phase)
            i2cm_seq_pkg::PH_REQ_DEV: begin
              phase_next = i2cm_seq_pkg::PH_WRITE;
            end
            i2cm_seq_pkg::PH_WRITE: begin
              bytes_written_next = wr_count_inc;
              if (wr_last) begin
                phase_next = read_wanted ? i2cm_seq_pkg::PH_REQ_READ
                                         : i2cm_seq_pkg::PH_CLOSE;
              end
            end
            i2cm_seq_pkg::PH_REQ_READ: begin
              phase_next = i2cm_seq_pkg::PH_READ;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
        i2cm_seq_pkg::CMD_RX: begin
          bytes_read_next = rd_count_inc;
          if (rd_last) begin
            phase_next = i2cm_seq_pkg::PH_CLOSE;
          end
        end
        i2cm_seq_pkg::CMD_STOP_DONE: begin
          phase_next = i2cm_seq_pkg::PH_IDLE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Result fields; an illegal event reports only fault and idle.
  always_comb begin
    res_next = '0;
    if (legal) begin
      case (s1.command)
        i2cm_seq_pkg::CMD_START: begin
          res_next.bus_command = i2cm_seq_pkg::BUS_START;
          res_next.tx_valid    = 1'b1;
          res_next.tx_byte     = i2cm_seq_pkg::addr_byte(s1.dev_addr, 1'b0);
        end
        i2cm_seq_pkg::CMD_ACK: begin
          case (phase)
            i2cm_seq_pkg::PH_REQ_DEV: begin
              res_next.tx_valid = 1'b1;
              res_next.tx_byte  = buf_data;
            end
            i2cm_seq_pkg::PH_WRITE: begin
              if (!wr_last) begin
                res_next.tx_valid = 1'b1;
                res_next.tx_byte  = buf_data;
              end else if (read_wanted) begin
                res_next.bus_command = i2cm_seq_pkg::BUS_START;
                res_next.tx_valid    = 1'b1;
                res_next.tx_byte     = i2cm_seq_pkg::addr_byte(target_address, 1'b1);
              end else begin
                res_next.bus_command = i2cm_seq_pkg::BUS_STOP;
              end
            end
            default: begin
              res_next.bus_command = i2cm_seq_pkg::BUS_NONE;
            end
          endcase
        end
        i2cm_seq_pkg::CMD_NACK: begin
          res_next.bus_command = i2cm_seq_pkg::BUS_START;
          res_next.tx_valid    = 1'b1;
          res_next.tx_byte     = i2cm_seq_pkg::addr_byte(target_address, 1'b1);
        end
        i2cm_seq_pkg::CMD_RX: begin
          res_next.read_valid  = 1'b1;
          res_next.read_index  = bytes_read;
          res_next.read_byte   = s1.data_byte;
          res_next.bus_command = rd_last ? i2cm_seq_pkg::BUS_NACK_STOP
                                         : i2cm_seq_pkg::BUS_ACK;
        end
        i2cm_seq_pkg::CMD_STOP_DONE: begin
          res_next.done_res = 1'b1;
          res_next.done_tag = saved_tag;
        end
        default: begin
          res_next.bus_command = i2cm_seq_pkg::BUS_NONE;
        end
      endcase
    end
    res_next.fault = !legal;
    res_next.idle  = (phase_next == i2cm_seq_pkg::PH_IDLE);
  end

  // State advances as the event's result is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cm_seq_pkg::PH_IDLE;
      target_address <= 7'd0;
      read_wanted    <= 1'b0;
      write_total    <= 5'd0;
      read_total     <= 8'd0;
      bytes_written  <= 5'd0;
      bytes_read     <= 8'd0;
      saved_tag      <= 32'd0;
    end else if (advance) begin
      phase          <= phase_next;
      target_address <= target_address_next;
      read_wanted    <= read_wanted_next;
      write_total    <= write_total_next;
      read_total     <= read_total_next;
      bytes_written  <= bytes_written_next;
      bytes_read     <= bytes_read_next;
      saved_tag      <= saved_tag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.bus_command = res.bus_command;
  assign result.tx_valid    = res.tx_valid;
  assign result.tx_byte     = res.tx_byte;
  assign result.read_valid  = res.read_valid;
  assign result.read_index  = res.read_index;
  assign result.read_byte   = res.read_byte;
  assign result.done_res    = res.done_res;
  assign result.done_tag    = res.done_tag;
  assign result.fault       = res.fault;
  assign result.idle        = res.idle;

endmodule

### rtl/i2cm_seq_chk.sv
// ----------------------------------------------------------------------------
// I2C master sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_macros.svh"

module i2cm_seq_chk (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  bus_command,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic        read_valid,
  input logic [7:0]  read_index,
  input logic [7:0]  read_byte,
  input logic        done_res,
  input logic [31:0] done_tag,
  input logic        fault,
  input logic        idle
);

  // A stalled result stays valid and keeps its command, bytes, tag and fault flag until it is transferred.
  `I2CM_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(bus_command) && $stable(tx_byte) && $stable(read_byte) && $stable(done_tag) && $stable(fault), "result changed while stalled")

  // A fault result carries no bus action, byte or completion.
  `I2CM_ASSERT_IMP(a_fault_quiet, clk, rst, res_valid && fault, (bus_command == i2cm_seq_pkg::BUS_NONE) && !tx_valid && !read_valid && !done_res, "fault result with activity")

  // Completion always leaves the sequencer idle; a final read never does.
  `I2CM_ASSERT_IMP(a_done_idle, clk, rst, res_valid && (done_res || (bus_command == i2cm_seq_pkg::BUS_NACK_STOP)), (done_res && idle) || (read_valid && !idle), "completion and idle disagree")

  // Data fields are zero whenever their flag is low.
  `I2CM_ASSERT_IMP(a_zero_fields, clk, rst, res_valid, (tx_valid || (tx_byte == 8'd0)) && (read_valid || ((read_index == 8'd0) && (read_byte == 8'd0))) && (done_res || (done_tag == 32'd0)), "field set without its flag")

endmodule

bind i2c_master_transaction_sequencer i2cm_seq_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .bus_command (result.bus_command),
  .tx_valid    (result.tx_valid),
  .tx_byte     (result.tx_byte),
  .read_valid  (result.read_valid),
  .read_index  (result.read_index),
  .read_byte   (result.read_byte),
  .done_res    (result.done_res),
  .done_tag    (result.done_tag),
  .fault       (result.fault),
  .idle        (result.idle)
);
